// ----- hw/rtl/lcd_timing_and_status_registers_macros.svh -----
// ---------------------------------------------------------------------------
// lcd timing and status registers - assertion macros
// shared property templates for the checker
// ---------------------------------------------------------------------------
`ifndef LCD_TIMING_AND_STATUS_REGISTERS_MACROS_SVH
`define LCD_TIMING_AND_STATUS_REGISTERS_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define LTSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lcd timing check failed");

// next-cycle implication, ignored while reset is held
`define LTSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lcd timing check failed");

`endif

// ----- hw/rtl/lcd_tsr_pkg.sv -----
// ---------------------------------------------------------------------------
// lcd timing and status registers - package
// command codes, register offsets, timing constants and word types
// ---------------------------------------------------------------------------
package lcd_tsr_pkg;

    localparam logic [7:0]  VISIBLE_LINES = 8'd160;
    localparam logic [8:0]  TOTAL_LINES   = 9'd227;
    localparam logic [7:0]  LINE_RESET    = 8'd126;
    localparam logic [15:0] DISPCNT_RESET = 16'h0080;

    // status word bit positions
    localparam int STAT_VBLANK    = 0;
    localparam int STAT_HBLANK    = 1;
    localparam int STAT_MATCH     = 2;
    localparam int STAT_VBLANK_IE = 3;
    localparam int STAT_HBLANK_IE = 4;
    localparam int STAT_MATCH_IE  = 5;

    // display modes that get a line render
    localparam logic [2:0] MODE_TILE0   = 3'd0;
    localparam logic [2:0] MODE_BITMAP3 = 3'd3;
    localparam logic [2:0] MODE_BITMAP4 = 3'd4;
    localparam logic [2:0] MODE_BITMAP5 = 3'd5;

    // register window byte offsets
    localparam logic [4:0] ADDR_DISPCNT_LO  = 5'h00;
    localparam logic [4:0] ADDR_DISPCNT_HI  = 5'h01;
    localparam logic [4:0] ADDR_DISPSTAT_LO = 5'h04;
    localparam logic [4:0] ADDR_DISPSTAT_HI = 5'h05;
    localparam logic [4:0] ADDR_VCOUNT      = 5'h06;
    localparam logic [4:0] ADDR_BGCNT_FIRST = 5'h08;
    localparam logic [4:0] ADDR_BGCNT_LAST  = 5'h0F;
    localparam logic [4:0] ADDR_SCROLL_FIRST = 5'h10;
    localparam logic [4:0] ADDR_SCROLL_LAST  = 5'h1F;

    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_HBL_START = 2'd2,
        CMD_HBL_END   = 2'd3
    } t_lcd_cmd;

    typedef struct packed {
        t_lcd_cmd   cmd;
        logic [4:0] address;
        logic [7:0] wdata;
    } t_lcd_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_hblank;
        logic       irq_vblank;
        logic       irq_vcount;
        logic       draw_line;
        logic [2:0] draw_mode;
        logic [7:0] draw_row;
        logic       draw_page;
        logic       frame_ready;
    } t_lcd_out;

endpackage

// ----- hw/rtl/lcd_timing_and_status_registers.sv -----
// ---------------------------------------------------------------------------
// lcd timing and status registers
// Byte-wide register window (display control, status, line counter, four
// background control and scroll registers) plus the line timing events. An
// item is captured in an input register; once the output register is free or
// being taken, it updates the registers and its result word is written into
// the output register. A new item is taken every cycle as long as the output
// side keeps up. Throughput is set by the single update path between the
// input register and the output register; the output register parts the two
// sides, so an item can still enter an empty input register while a result waits.
// ---------------------------------------------------------------------------
module lcd_timing_and_status_registers (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  lcd_tsr_pkg::t_lcd_in i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output lcd_tsr_pkg::t_lcd_out o_out_data,
    input  logic                 i_out_stall
);
    import lcd_tsr_pkg::*;

    logic        r_s1_valid;
    t_lcd_in     r_s1;
    logic        r_out_valid;
    t_lcd_out    r_out;

    logic [15:0] r_dispcnt, n_dispcnt;
    logic [15:0] r_dispstat, n_dispstat;
    logic [7:0]  r_line, n_line;
    logic [15:0] r_bgcnt   [4];
    logic [15:0] n_bgcnt   [4];
    logic [8:0]  r_hscroll [4];
    logic [8:0]  n_hscroll [4];
    logic [8:0]  r_vscroll [4];
    logic [8:0]  n_vscroll [4];

    t_lcd_out    res;
    logic        s1_adv;
    logic        in_acc;
    logic [8:0]  line_inc;
    logic [2:0]  mode;
    logic [15:0] bg_word;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign mode     = r_dispcnt[2:0];
    assign line_inc = {1'b0, r_line} + 9'd1;
    assign bg_word  = r_bgcnt[r_s1.address[2:1]];

    always_comb begin
        n_dispcnt  = r_dispcnt;
        n_dispstat = r_dispstat;
        n_line     = r_line;
        n_bgcnt    = r_bgcnt;
        n_hscroll  = r_hscroll;
        n_vscroll  = r_vscroll;
        res        = '0;

        case (r_s1.cmd)
            CMD_READ: begin
                unique case (r_s1.address) inside
                    ADDR_DISPCNT_LO:  res.rdata = r_dispcnt[7:0];
                    ADDR_DISPCNT_HI:  res.rdata = r_dispcnt[15:8];
                    ADDR_DISPSTAT_LO: res.rdata = r_dispstat[7:0];
                    ADDR_DISPSTAT_HI: res.rdata = r_dispstat[15:8];
                    ADDR_VCOUNT:      res.rdata = r_line;
                    [ADDR_BGCNT_FIRST:ADDR_BGCNT_LAST]: begin
                        res.rdata = r_s1.address[0] ? bg_word[15:8] : bg_word[7:0];
                    end
                    default:          res.rdata = '0;
                endcase
            end
            CMD_WRITE: begin
                unique case (r_s1.address) inside
                    ADDR_DISPCNT_LO:  n_dispcnt[7:0]  = r_s1.wdata;
                    ADDR_DISPCNT_HI:  n_dispcnt[15:8] = r_s1.wdata;
                    // only the interrupt enables are writable in the low byte
                    ADDR_DISPSTAT_LO: begin
                        n_dispstat[STAT_MATCH_IE:STAT_VBLANK_IE] =
                            r_s1.wdata[STAT_MATCH_IE:STAT_VBLANK_IE];
                    end
                    ADDR_DISPSTAT_HI: n_dispstat[15:8] = r_s1.wdata;
                    [ADDR_BGCNT_FIRST:ADDR_BGCNT_LAST]: begin
                        if (r_s1.address[0]) begin
                            n_bgcnt[r_s1.address[2:1]][15:8] = r_s1.wdata;
                        end else begin
                            n_bgcnt[r_s1.address[2:1]][7:0] = r_s1.wdata;
                        end
                    end
                    [ADDR_SCROLL_FIRST:ADDR_SCROLL_LAST]: begin
                        // offset bit 1 picks vertical, bit 0 the high byte
                        if (r_s1.address[1]) begin
                            if (r_s1.address[0]) begin
                                n_vscroll[r_s1.address[3:2]][8] = r_s1.wdata[0];
                            end else begin
                                n_vscroll[r_s1.address[3:2]][7:0] = r_s1.wdata;
                            end
                        end else begin
                            if (r_s1.address[0]) begin
                                n_hscroll[r_s1.address[3:2]][8] = r_s1.wdata[0];
                            end else begin
                                n_hscroll[r_s1.address[3:2]][7:0] = r_s1.wdata;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_HBL_START: begin
                n_dispstat[STAT_HBLANK] = 1'b1;
                res.irq_hblank = r_dispstat[STAT_HBLANK_IE];
                if (r_line < VISIBLE_LINES) begin
                    case (mode) inside
                        MODE_TILE0, MODE_BITMAP3, MODE_BITMAP4, MODE_BITMAP5: begin
                            res.draw_line = 1'b1;
                            res.draw_mode = mode;
                            res.draw_row  = r_line;
                            res.draw_page = (mode == MODE_BITMAP4 || mode == MODE_BITMAP5)
                                            && r_dispcnt[4];
                        end
                        default: ;
                    endcase
                end
            end
            default: begin
                // hblank end: advance the line counter and update the status flags
                n_dispstat[STAT_HBLANK] = 1'b0;
                n_dispstat[STAT_MATCH]  = 1'b0;
                if (line_inc >= TOTAL_LINES) begin
                    n_line = '0;
                    n_dispstat[STAT_VBLANK] = 1'b0;
                end else begin
                    n_line = line_inc[7:0];
                end
                if (n_line == r_dispstat[15:8]) begin
                    n_dispstat[STAT_MATCH] = 1'b1;
                    res.irq_vcount = r_dispstat[STAT_MATCH_IE];
                end
                if (n_line == VISIBLE_LINES) begin
                    n_dispstat[STAT_VBLANK] = 1'b1;
                    res.frame_ready = 1'b1;
                    res.irq_vblank  = r_dispstat[STAT_VBLANK_IE];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dispcnt   <= DISPCNT_RESET;
            r_dispstat  <= '0;
            r_line      <= LINE_RESET;
            for (int i = 0; i < 4; i++) begin
                r_bgcnt[i]   <= '0;
                r_hscroll[i] <= '0;
                r_vscroll[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_dispcnt   <= n_dispcnt;
                r_dispstat  <= n_dispstat;
                r_line      <= n_line;
                r_bgcnt     <= n_bgcnt;
                r_hscroll   <= n_hscroll;
                r_vscroll   <= n_vscroll;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_data;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

endmodule

// ----- hw/rtl/lcd_tsr_checker.sv -----
// ---------------------------------------------------------------------------
// lcd timing and status registers - port checker
// tracks words in flight and checks the result words seen on the ports
// ---------------------------------------------------------------------------
`include "lcd_timing_and_status_registers_macros.svh"

module lcd_tsr_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input lcd_tsr_pkg::t_lcd_in  i_in_data,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input lcd_tsr_pkg::t_lcd_out o_out_data,
    input logic                  i_out_stall
);
    import lcd_tsr_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_inflight;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_acc && !out_acc) begin
            r_inflight <= r_inflight + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_inflight <= r_inflight - 2'd1;
        end
    end

    // two register stages hold at most two words
    `LTSR_ASSERT_IMPLY(a_inflight_max, i_clk, i_rst_n, 1'b1, r_inflight != 2'd3)
    // no result word without an accepted input word
    `LTSR_ASSERT_IMPLY(a_no_phantom, i_clk, i_rst_n, o_out_valid, r_inflight != 2'd0)
    // a render request only targets a visible line
    `LTSR_ASSERT_IMPLY(a_draw_row, i_clk, i_rst_n, o_out_valid && o_out_data.draw_line,
        o_out_data.draw_row < VISIBLE_LINES && !o_out_data.frame_ready)
    `LTSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data))

endmodule

bind lcd_timing_and_status_registers lcd_tsr_checker u_lcd_tsr_checker (.*);
